FILE: design/spring_force_3d_defines.svh
// Assertion macros used by the spring force back pipeline (sf3d_back).
`ifndef SPRING_FORCE_3D_DEFINES_SVH
`define SPRING_FORCE_3D_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SF_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an event is followed by another in the next cycle.
`define SF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sf3d_pkg.sv
`timescale 1ns / 1ps
package sf3d_pkg;

    localparam int PosW   = 32;
    localparam int DeltaW = 33;
    localparam int MagW   = 32;
    localparam int SqW    = 66;
    localparam int LenW   = 33;
    localparam int RestW  = 31;
    localparam int StretchW = 34;
    localparam int KsW    = 65;
    localparam int DirW   = 31;
    localparam int RemW   = 35;
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    localparam logic [1:0] CfgEnabled = 2'd0;
    localparam logic [1:0] CfgRest    = 2'd1;
    localparam logic [1:0] CfgStiff   = 2'd2;

    typedef struct packed {
        logic signed [DeltaW-1:0] dx;
        logic signed [DeltaW-1:0] dy;
        logic signed [DeltaW-1:0] dz;
        logic                     has_b;
    } sf3d_item_t;

endpackage

FILE: design/sf3d_front.sv
`timescale 1ns / 1ps
module sf3d_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic                    enabled,
    input  logic signed [31:0]      pos_a_x,
    input  logic signed [31:0]      pos_a_y,
    input  logic signed [31:0]      pos_a_z,
    input  logic signed [31:0]      pos_b_x,
    input  logic signed [31:0]      pos_b_y,
    input  logic signed [31:0]      pos_b_z,
    input  logic                    has_body_b,
    output logic                    item_valid,
    output sf3d_pkg::sf3d_item_t    item
);
    import sf3d_pkg::*;

    logic       valid_reg;
    sf3d_item_t item_reg;
    sf3d_item_t item_next;

    // The item is classified here: disabled transactions are dropped, and an
    // absent body B is replaced by the origin.
    always_comb
    begin
        item_next.has_b = has_body_b;
        item_next.dx = DeltaW'(pos_a_x) - (has_body_b ? DeltaW'(pos_b_x) : '0);
        item_next.dy = DeltaW'(pos_a_y) - (has_body_b ? DeltaW'(pos_b_y) : '0);
        item_next.dz = DeltaW'(pos_a_z) - (has_body_b ? DeltaW'(pos_b_z) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take && enabled;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;
endmodule

FILE: design/sf3d_queue.sv
`timescale 1ns / 1ps
module sf3d_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sf3d_pkg::sf3d_item_t push_item,
    input  logic                 pop,
    output logic                 not_empty,
    output sf3d_pkg::sf3d_item_t head
);
    import sf3d_pkg::*;

    sf3d_item_t       mem [QDepth];
    logic [QPtrW-1:0] wr_reg;
    logic [QPtrW-1:0] rd_reg;
    logic [QPtrW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign head = mem[rd_reg];
endmodule

FILE: design/sf3d_back.sv
`timescale 1ns / 1ps
`include "spring_force_3d_defines.svh"
module sf3d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sf3d_pkg::sf3d_item_t in_item,
    input  logic [30:0]          rest_len,
    input  logic signed [31:0]   stiffness,
    output logic                 out_valid,
    output logic signed [31:0]   force_x,
    output logic signed [31:0]   force_y,
    output logic signed [31:0]   force_z,
    output logic                 apply_opposite_to_b,
    output logic                 saturated
);
    import sf3d_pkg::*;

    // Stage counts: squares(1) sum(1) root(33) stretch/ks(2) divide(31) mult(2)
    localparam int SqrtSteps = 33;
    localparam int DivSteps  = 31;

    // Stage 1: magnitudes squared.
    logic               v1_reg;
    logic [63:0]        sq_reg [3];
    logic [MagW:0]      m1_reg [3];
    logic [2:0]         n1_reg;
    logic               hb1_reg;
    logic [MagW:0]      mag_c [3];

    always_comb
    begin
        mag_c[0] = in_item.dx[DeltaW-1] ? (MagW+1)'(-in_item.dx) : (MagW+1)'(in_item.dx);
        mag_c[1] = in_item.dy[DeltaW-1] ? (MagW+1)'(-in_item.dy) : (MagW+1)'(in_item.dy);
        mag_c[2] = in_item.dz[DeltaW-1] ? (MagW+1)'(-in_item.dz) : (MagW+1)'(in_item.dz);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            m1_reg[i] <= mag_c[i];
            sq_reg[i] <= 64'(mag_c[i]) * 64'(mag_c[i]);
        end
        n1_reg  <= {in_item.dz[DeltaW-1], in_item.dy[DeltaW-1], in_item.dx[DeltaW-1]};
        hb1_reg <= in_item.has_b;
    end

    // Stage 2: sum of squares.
    logic          v2_reg;
    logic [SqW-1:0] sum_reg;
    logic [MagW:0] m2_reg [3];
    logic [2:0]    n2_reg;
    logic          hb2_reg;

    always_ff @(posedge clk)
    begin
        sum_reg <= SqW'(sq_reg[0]) + SqW'(sq_reg[1]) + SqW'(sq_reg[2]);
        m2_reg  <= m1_reg;
        n2_reg  <= n1_reg;
        hb2_reg <= hb1_reg;
    end

    // Square root: one result bit per stage.
    logic           sv_reg  [SqrtSteps+1];
    logic [SqW-1:0] srad_reg [SqrtSteps+1];
    logic [LenW+1:0] srem_reg [SqrtSteps+1];
    logic [LenW-1:0] sroot_reg [SqrtSteps+1];
    logic [MagW:0]  sm_reg  [SqrtSteps+1][3];
    logic [2:0]     sn_reg  [SqrtSteps+1];
    logic           shb_reg [SqrtSteps+1];

    always_comb
    begin
        srad_reg[0]  = sum_reg;
        srem_reg[0]  = '0;
        sroot_reg[0] = '0;
        sm_reg[0]    = m2_reg;
        sn_reg[0]    = n2_reg;
        shb_reg[0]   = hb2_reg;
        sv_reg[0]    = v2_reg;
    end

    for (genvar g = 0; g < SqrtSteps; g++)
    begin : g_sqrt
        logic [LenW+1:0] rem_c;
        logic [LenW+1:0] trial_c;
        always_comb
        begin
            rem_c   = {srem_reg[g][LenW-1:0], srad_reg[g][SqW-1 -: 2]};
            trial_c = {sroot_reg[g], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            srad_reg[g+1] <= {srad_reg[g][SqW-3:0], 2'b00};
            if (rem_c >= trial_c)
            begin
                srem_reg[g+1]  <= rem_c - trial_c;
                sroot_reg[g+1] <= {sroot_reg[g][LenW-2:0], 1'b1};
            end
            else
            begin
                srem_reg[g+1]  <= rem_c;
                sroot_reg[g+1] <= {sroot_reg[g][LenW-2:0], 1'b0};
            end
            sm_reg[g+1]  <= sm_reg[g];
            sn_reg[g+1]  <= sn_reg[g];
            shb_reg[g+1] <= shb_reg[g];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[g+1] <= 1'b0;
            end
            else
            begin
                sv_reg[g+1] <= sv_reg[g];
            end
        end
    end

    // Stage A: stretch and sign. Stage B: |k| * |s|.
    logic                    va_reg;
    logic signed [StretchW-1:0] s_reg;
    logic [LenW-1:0]         lena_reg;
    logic [MagW:0]           ma_reg [3];
    logic [2:0]              na_reg;
    logic                    hba_reg;
    logic                    kneg_a_reg;
    logic [31:0]             kmag_a_reg;

    always_ff @(posedge clk)
    begin
        s_reg <= StretchW'(sroot_reg[SqrtSteps]) - StretchW'(rest_len);
        lena_reg <= sroot_reg[SqrtSteps];
        ma_reg   <= sm_reg[SqrtSteps];
        na_reg   <= sn_reg[SqrtSteps];
        hba_reg  <= shb_reg[SqrtSteps];
        kneg_a_reg <= stiffness[31];
        kmag_a_reg <= stiffness[31] ? 32'(-33'(stiffness)) : 32'(stiffness);
    end

    logic               vb_reg;
    logic [KsW-1:0]     ks_reg;
    logic               nks_reg;
    logic [LenW-1:0]    lenb_reg;
    logic [MagW:0]      mb_reg [3];
    logic [2:0]         nb_reg;
    logic               hbb_reg;
    logic [StretchW-1:0] smag_c;

    always_comb
    begin
        smag_c = s_reg[StretchW-1] ? StretchW'(-s_reg) : StretchW'(s_reg);
    end

    always_ff @(posedge clk)
    begin
        ks_reg   <= KsW'(kmag_a_reg) * KsW'(smag_c);
        nks_reg  <= !(kneg_a_reg != s_reg[StretchW-1]);
        lenb_reg <= lena_reg;
        mb_reg   <= ma_reg;
        nb_reg   <= na_reg;
        hbb_reg  <= hba_reg;
    end

    // Divide |d| * 2^30 / L, three lanes, one quotient bit per stage.
    logic               dv_reg  [DivSteps+1];
    logic [RemW-1:0]    drem_reg [DivSteps+1][3];
    logic [MagW:0]      dnum_reg [DivSteps+1][3];
    logic [DirW-1:0]    dq_reg  [DivSteps+1][3];
    logic [LenW-1:0]    dlen_reg [DivSteps+1];
    logic [KsW-1:0]     dks_reg [DivSteps+1];
    logic               dnks_reg [DivSteps+1];
    logic [2:0]         dn_reg  [DivSteps+1];
    logic               dhb_reg [DivSteps+1];

    // The top 30 bits of |d| * 2^30 / L below numerator shift give zero
    // quotient bits only if |d| < L; since |d| <= L the quotient is at most
    // 2^30 and fits in 31 bits. Seed the remainder with |d| and shift zeros.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            drem_reg[0][i] = '0;
            dnum_reg[0][i] = mb_reg[i];
            dq_reg[0][i]   = '0;
        end
        dv_reg[0]   = vb_reg;
        dlen_reg[0] = lenb_reg;
        dks_reg[0]  = ks_reg;
        dnks_reg[0] = nks_reg;
        dn_reg[0]   = nb_reg;
        dhb_reg[0]  = hbb_reg;
    end

    // Numerator bits: first the top bit of |d| (which equals quotient bit 30
    // after 33 bits); handled by seeding: quotient bit 30 comes from
    // (|d| >= L), remainder |d| - L or |d|, then 30 bits of zeros.
    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        logic [RemW-1:0] r_c [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (g == 0)
                begin
                    r_c[i] = RemW'(dnum_reg[g][i]);
                end
                else
                begin
                    r_c[i] = {drem_reg[g][i][RemW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (r_c[i] >= RemW'(dlen_reg[g]) && dlen_reg[g] != '0)
                begin
                    drem_reg[g+1][i] <= r_c[i] - RemW'(dlen_reg[g]);
                    dq_reg[g+1][i]   <= {dq_reg[g][i][DirW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[g+1][i] <= r_c[i];
                    dq_reg[g+1][i]   <= {dq_reg[g][i][DirW-2:0], 1'b0};
                end
                dnum_reg[g+1][i] <= dnum_reg[g][i];
            end
            dlen_reg[g+1] <= dlen_reg[g];
            dks_reg[g+1]  <= dks_reg[g];
            dnks_reg[g+1] <= dnks_reg[g];
            dn_reg[g+1]   <= dn_reg[g];
            dhb_reg[g+1]  <= dhb_reg[g];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[g+1] <= 1'b0;
            end
            else
            begin
                dv_reg[g+1] <= dv_reg[g];
            end
        end
    end

    // Product ks * dir split in two partial products over two stages.
    logic            vm_reg;
    logic [63:0]     plo_reg [3];
    logic [63:0]     phi_reg [3];
    logic            mneg_reg [3];
    logic            mz_reg;
    logic            mhb_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            plo_reg[i]  <= 64'(dks_reg[DivSteps][31:0]) * 64'(dq_reg[DivSteps][i]);
            phi_reg[i]  <= 64'(dks_reg[DivSteps][KsW-1:32]) * 64'(dq_reg[DivSteps][i]);
            mneg_reg[i] <= dn_reg[DivSteps][i] != dnks_reg[DivSteps];
        end
        mz_reg  <= (dlen_reg[DivSteps] == '0);
        mhb_reg <= dhb_reg[DivSteps];
    end

    logic        vo_reg;
    logic [31:0] f_reg [3];
    logic        sat_reg;
    logic        hbo_reg;
    logic [31:0] f_c [3];
    logic [2:0]  sat_c;
    logic [63:0] mag_f [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_f[i] = (phi_reg[i] + (plo_reg[i] >> 32)) >> 14;
            sat_c[i] = 1'b0;
            if (mz_reg || mag_f[i] == '0)
            begin
                f_c[i] = '0;
            end
            else if (mneg_reg[i])
            begin
                if (mag_f[i] > 64'h8000_0000)
                begin
                    f_c[i] = 32'h8000_0000;
                    sat_c[i] = 1'b1;
                end
                else
                begin
                    f_c[i] = 32'(-mag_f[i]);
                end
            end
            else if (mag_f[i] > 64'h7FFF_FFFF)
            begin
                f_c[i] = 32'h7FFF_FFFF;
                sat_c[i] = 1'b1;
            end
            else
            begin
                f_c[i] = mag_f[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg   <= f_c;
        sat_reg <= |sat_c;
        hbo_reg <= mhb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            va_reg <= sv_reg[SqrtSteps];
            vb_reg <= va_reg;
            vm_reg <= dv_reg[DivSteps];
            vo_reg <= vm_reg;
        end
    end

    assign out_valid = vo_reg;
    assign force_x = f_reg[0];
    assign force_y = f_reg[1];
    assign force_z = f_reg[2];
    assign apply_opposite_to_b = hbo_reg;
    assign saturated = sat_reg;

    `SF_ASSERT_NEXT(a_valid_flow, clk, rst_n, vm_reg, vo_reg, "result strobe lost")
    `SF_ASSERT_IMP(a_sat_nonzero, clk, rst_n, vo_reg && sat_reg,
        (f_reg[0] != '0 || f_reg[1] != '0 || f_reg[2] != '0), "saturated but zero force")
    `SF_ASSERT_NEXT(a_div_flow, clk, rst_n, vb_reg, dv_reg[1], "divider entry lost")
endmodule

FILE: design/spring_force_3d.sv
`timescale 1ns / 1ps
// Hooke spring force between two bodies, signed Q16.16.
// A transaction is accepted at a rising edge with start high and busy low;
// busy stays low, so one transaction can be taken every cycle.
// Configuration: cfg_we, cfg_index (0 enable, 1 rest length, 2 stiffness)
// and cfg_data, written at the clock edge; other indexes are ignored.
// The front stage forms delta = A - B (origin when has_body_b is low) and
// drops transactions while the spring is disabled. A short queue hands the
// item to the back pipeline, which takes the square root one bit a stage,
// the stretch, |k*s|, three direction quotients one bit a stage, and the
// final product in two partial products.
// An item goes from acceptance through front, queue and back to the done
// strobe; throughput is one result per cycle. A result is shown for one
// cycle while done is high and cannot be held off by the receiver.
// Reset clears all valid flags and loads enable=1, rest length 0 and
// stiffness 0; no clearing pass is needed.
module spring_force_3d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] pos_a_x,
    input  logic signed [31:0] pos_a_y,
    input  logic signed [31:0] pos_a_z,
    input  logic signed [31:0] pos_b_x,
    input  logic signed [31:0] pos_b_y,
    input  logic signed [31:0] pos_b_z,
    input  logic               has_body_b,
    output logic               done,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic               apply_opposite_to_b,
    output logic               saturated
);
    import sf3d_pkg::*;

    logic        enabled_reg;
    logic [30:0] rest_reg;
    logic signed [31:0] stiff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            rest_reg    <= '0;
            stiff_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgEnabled: enabled_reg <= cfg_data[0];
                CfgRest:    rest_reg    <= cfg_data[30:0];
                CfgStiff:   stiff_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic       take;
    logic       f_valid;
    sf3d_item_t f_item;
    logic       q_ne;
    sf3d_item_t q_head;

    // The back pipeline never stalls, so the queue drains every cycle.
    assign busy = 1'b0;
    assign take = start && !busy;

    sf3d_front u_front (
        .clk, .rst_n, .take, .enabled(enabled_reg),
        .pos_a_x, .pos_a_y, .pos_a_z, .pos_b_x, .pos_b_y, .pos_b_z, .has_body_b,
        .item_valid(f_valid), .item(f_item)
    );

    sf3d_queue u_queue (
        .clk, .rst_n, .push(f_valid), .push_item(f_item),
        .pop(q_ne), .not_empty(q_ne), .head(q_head)
    );

    sf3d_back u_back (
        .clk, .rst_n, .in_valid(q_ne), .in_item(q_head),
        .rest_len(rest_reg), .stiffness(stiff_reg),
        .out_valid(done), .force_x, .force_y, .force_z,
        .apply_opposite_to_b, .saturated
    );
endmodule
